@@ rtl/assert_macros.svh @@
// Assertion helpers used by the receiver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SFR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfr assertion failed");

// Next-cycle implication, checked outside reset.
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfr assertion failed");

`endif

@@ rtl/sfr_pkg.sv @@
package sfr_pkg;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ADDR = 2'd1,
    PH_LEN  = 2'd2,
    PH_BODY = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_ADDR = 2'd0,
    KIND_LEN  = 2'd1,
    KIND_PAY  = 2'd2,
    KIND_SUM  = 2'd3
  } kind_e;

  localparam logic [0:0] CFG_SYNC = 1'b0;
  localparam logic [0:0] CFG_ESC  = 1'b1;

  localparam logic [7:0] SYNC_RESET = 8'hE0;
  localparam logic [7:0] ESC_RESET  = 8'hD0;

  typedef struct packed {
    phase_e     phase;
    logic       esc_pend;
    logic [7:0] frame_len;
    logic [7:0] pay_cnt;
    logic [7:0] sum;
  } state_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    kind_e      kind;
    logic       frame_end;
    logic       ok;
  } result_t;

endpackage

@@ rtl/serial_frame_receiver.sv @@
// Serial frame receiver. Takes one raw byte per input item and decodes a
// byte-stuffed frame: a sync byte (re)starts the frame from any phase, an
// escape byte is dropped and the byte after it is taken plus one. Each
// decoded byte comes out as one result item tagged address, length,
// payload or checksum; the checksum item (or a zero length) closes the
// frame and reports whether the checksum matched the 8-bit sum of address,
// length and payload. Bytes outside a frame, sync and escape bytes give no
// result. The block takes one item per cycle while the result side keeps
// up: a byte is held in the input register, is decoded in a single pass
// against the frame state and lands in the result register, where it waits
// to be taken. The input side stalls only while an untaken result sits in
// the result register and the byte in the input register would produce
// another. The sync and escape values are written through the configuration
// port (index 0 sync, index 1 escape); the user writes them only while the
// block is idle, and the block itself does not enforce that.
module serial_frame_receiver (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] data_byte_o,
  output logic [1:0] byte_kind_o,
  output logic       frame_end_o,
  output logic       checksum_ok_o
);
  import sfr_pkg::*;

  `include "assert_macros.svh"

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic [7:0] sync_q;
  logic [7:0] esc_q;
  state_t     state_q;
  state_t     state_d;
  result_t    res;
  logic       out_vld_q;
  logic [7:0] out_data_q;
  kind_e      out_kind_q;
  logic       out_end_q;
  logic       out_ok_q;
  logic       slot_free;
  logic       advance;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= SYNC_RESET;
      esc_q  <= ESC_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SYNC: sync_q <= cfg_data_i;
        CFG_ESC:  esc_q  <= cfg_data_i;
        default:  sync_q <= sync_q;
      endcase
    end
  end

  // decode the held byte against the current frame state
  sfr_decode u_decode (
    .state_i (state_q),
    .byte_i  (in_byte_q),
    .sync_i  (sync_q),
    .esc_i   (esc_q),
    .state_o (state_d),
    .res_o   (res)
  );

  // the result register is free if empty or being drained this cycle
  assign slot_free  = !out_vld_q || out_ready_i;
  // advance the held byte unless its result has nowhere to go
  assign advance    = in_vld_q && (!res.valid || slot_free);
  assign in_ready_o = !in_vld_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // frame state: update only when the held byte is consumed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_IDLE, esc_pend: 1'b0, frame_len: 8'd0,
                   pay_cnt: 8'd0, sum: 8'd0};
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (slot_free) begin
      out_vld_q <= advance && res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free && advance && res.valid) begin
      out_data_q <= res.data;
      out_kind_q <= res.kind;
      out_end_q  <= res.frame_end;
      out_ok_q   <= res.ok;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign data_byte_o   = out_data_q;
  assign byte_kind_o   = out_kind_q;
  assign frame_end_o   = out_end_q;
  assign checksum_ok_o = out_ok_q;

  // a frame closes only on a length or checksum item
  `SFR_ASSERT_IMPL(a_end_kind, clk_i, rst_ni, out_vld_q && out_end_q,
                   out_kind_q == KIND_LEN || out_kind_q == KIND_SUM)
  // a checksum match is only reported on a closing item
  `SFR_ASSERT_IMPL(a_ok_end, clk_i, rst_ni, out_vld_q && out_ok_q, out_end_q)
  // a decoded result never comes from an idle receiver
  `SFR_ASSERT_IMPL(a_res_phase, clk_i, rst_ni, in_vld_q && res.valid,
                   state_q.phase != PH_IDLE)
  // a consumed sync byte always reopens the frame at the address
  `SFR_ASSERT_NEXT(a_sync_restart, clk_i, rst_ni, advance && (in_byte_q == sync_q),
                   state_q.phase == PH_ADDR && !state_q.esc_pend)

endmodule

@@ rtl/sfr_decode.sv @@
module sfr_decode (
  input  sfr_pkg::state_t  state_i,
  input  logic [7:0]       byte_i,
  input  logic [7:0]       sync_i,
  input  logic [7:0]       esc_i,
  output sfr_pkg::state_t  state_o,
  output sfr_pkg::result_t res_o
);
  import sfr_pkg::*;

  logic       is_sync;
  logic       is_esc;
  logic       takes;
  logic [7:0] val;
  logic       more;

  assign is_sync = (byte_i == sync_i);
  assign is_esc  = (byte_i == esc_i);
  // a byte that yields a result: in frame, neither sync nor escape
  assign takes   = !is_sync && (state_i.phase != PH_IDLE) && !is_esc;
  assign val     = state_i.esc_pend ? byte_i + 8'd1 : byte_i;
  assign more    = ({1'b0, state_i.pay_cnt} + 9'd1) < {1'b0, state_i.frame_len};

  // next state
  always_comb begin
    state_o = state_i;
    if (is_sync) begin
      state_o.phase    = PH_ADDR;
      state_o.esc_pend = 1'b0;
      state_o.sum      = 8'd0;
      state_o.pay_cnt  = 8'd0;
    end else if (state_i.phase == PH_IDLE) begin
      state_o = state_i;
    end else if (is_esc) begin
      state_o.esc_pend = 1'b1;
    end else begin
      state_o.esc_pend = 1'b0;
      unique case (state_i.phase)
        PH_ADDR: begin
          state_o.sum   = val;
          state_o.phase = PH_LEN;
        end
        PH_LEN: begin
          state_o.sum       = state_i.sum + val;
          state_o.frame_len = val;
          state_o.pay_cnt   = 8'd0;
          state_o.phase     = (val == 8'd0) ? PH_IDLE : PH_BODY;
        end
        PH_BODY: begin
          if (more) begin
            state_o.sum     = state_i.sum + val;
            state_o.pay_cnt = state_i.pay_cnt + 8'd1;
          end else begin
            state_o.phase = PH_IDLE;
          end
        end
        default: state_o.phase = state_i.phase;
      endcase
    end
  end

  // result
  always_comb begin
    res_o           = '0;
    res_o.data      = val;
    res_o.valid     = takes;
    res_o.kind      = KIND_ADDR;
    res_o.frame_end = 1'b0;
    res_o.ok        = 1'b0;
    unique case (state_i.phase)
      PH_ADDR: res_o.kind = KIND_ADDR;
      PH_LEN: begin
        res_o.kind      = KIND_LEN;
        res_o.frame_end = (val == 8'd0);
      end
      PH_BODY: begin
        if (more) begin
          res_o.kind = KIND_PAY;
        end else begin
          res_o.kind      = KIND_SUM;
          res_o.frame_end = 1'b1;
          res_o.ok        = (val == state_i.sum);
        end
      end
      default: res_o.valid = 1'b0;
    endcase
  end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import sfr_pkg::*;

  // Cycles without any handshake before the run is declared hung.
  localparam int STALL_LIMIT = 1000;
  // Minimum raw bytes, noise included, sent per code setting in the random part.
  localparam int PHASE_QUOTA = 235;
  localparam int NUM_PHASES  = 6;
  // Cycles to let a byte that makes no result drain out of the pipeline.
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic [7:0] data;
    kind_e      kind;
    logic       fend;
    logic       ok;
  } decoded_t;

  // Tracks the frame decoder state and holds the decoded bytes still owed
  // by the block, oldest first.
  class frame_scoreboard;
    logic [7:0] sync_byte;
    logic [7:0] esc_byte;
    phase_e     phase;
    bit         esc_pend;
    logic [7:0] frame_len;
    logic [7:0] pay_cnt;
    logic [7:0] run_sum;
    decoded_t   expected_q[$];
    int         failures;
    int         checked;
    int         frames_closed;
    int         good_sums;

    function new();
      sync_byte     = SYNC_RESET;
      esc_byte      = ESC_RESET;
      phase         = PH_IDLE;
      esc_pend      = 1'b0;
      frame_len     = '0;
      pay_cnt       = '0;
      run_sum       = '0;
      failures      = 0;
      checked       = 0;
      frames_closed = 0;
      good_sums     = 0;
    endfunction

    function void set_reg(logic [0:0] idx, logic [7:0] val);
      if (idx == CFG_SYNC) begin
        sync_byte = val;
      end else begin
        esc_byte = val;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Advance the decoder by one accepted raw byte; queue the result it owes.
    function void note_byte(logic [7:0] raw);
      logic [7:0] v;
      decoded_t   d;
      // Sync wins over everything, escape included.
      if (raw == sync_byte) begin
        phase    = PH_ADDR;
        esc_pend = 1'b0;
        run_sum  = '0;
        pay_cnt  = '0;
        return;
      end
      if (phase == PH_IDLE) return;
      // Escape stays pending across repeated escapes.
      if (raw == esc_byte) begin
        esc_pend = 1'b1;
        return;
      end
      v = raw;
      if (esc_pend) begin
        v        = v + 8'd1;
        esc_pend = 1'b0;
      end
      d.data = v;
      d.fend = 1'b0;
      d.ok   = 1'b0;
      case (phase)
        PH_ADDR: begin
          run_sum = v;
          phase   = PH_LEN;
          d.kind  = KIND_ADDR;
        end
        PH_LEN: begin
          run_sum   = run_sum + v;
          frame_len = v;
          pay_cnt   = '0;
          d.kind    = KIND_LEN;
          if (v == 8'd0) begin
            phase  = PH_IDLE;
            d.fend = 1'b1;
          end else begin
            phase = PH_BODY;
          end
        end
        default: begin
          if ({1'b0, pay_cnt} + 9'd1 < {1'b0, frame_len}) begin
            run_sum = run_sum + v;
            pay_cnt = pay_cnt + 8'd1;
            d.kind  = KIND_PAY;
          end else begin
            phase  = PH_IDLE;
            d.kind = KIND_SUM;
            d.fend = 1'b1;
            d.ok   = (v == run_sum);
          end
        end
      endcase
      expected_q.push_back(d);
    endfunction

    function void check_result(logic [7:0] data, logic [1:0] kind, logic fend, logic ok);
      decoded_t d;
      if (expected_q.size() == 0) begin
        $error("unexpected result: data_byte %0h byte_kind %0d", data, kind);
        failures++;
        return;
      end
      d = expected_q.pop_front();
      checked++;
      if (d.fend) frames_closed++;
      if (d.fend && d.ok) good_sums++;
      if (data !== d.data) begin
        $error("data_byte: expected %0h, got %0h", d.data, data);
        failures++;
      end
      if (kind !== 2'(d.kind)) begin
        $error("byte_kind: expected %0d, got %0d", d.kind, kind);
        failures++;
      end
      if (fend !== d.fend) begin
        $error("frame_end: expected %0b, got %0b", d.fend, fend);
        failures++;
      end
      if (ok !== d.ok) begin
        $error("checksum_ok: expected %0b, got %0b", d.ok, ok);
        failures++;
      end
    endfunction
  endclass

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       cfg_we_i      = 1'b0;
  logic [0:0] cfg_idx_i     = CFG_SYNC;
  logic [7:0] cfg_data_i    = '0;
  logic       in_valid_i    = 1'b0;
  logic       in_ready_o;
  logic [7:0] rx_byte_i     = '0;
  logic       out_valid_o;
  logic       out_ready_i   = 1'b0;
  logic [7:0] data_byte_o;
  logic [1:0] byte_kind_o;
  logic       frame_end_o;
  logic       checksum_ok_o;

  frame_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int bytes_sent    = 0;
  int stall_cycles  = 0;

  serial_frame_receiver dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .data_byte_o   (data_byte_o),
    .byte_kind_o   (byte_kind_o),
    .frame_end_o   (frame_end_o),
    .checksum_ok_o (checksum_ok_o)
  );

  always #5 clk_i = ~clk_i;

  // Result side: check each accepted item, then pick next cycle's ready.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(data_byte_o, byte_kind_o, frame_end_o, checksum_ok_o);
    end
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: any handshake on either side clears the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offer one raw byte, with random idle cycles ahead of it; return at the
  // edge where it is taken. Valid stays up when the next byte follows at once.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  // Send one decoded byte, escaping it when it collides with a code or at
  // random; now and then stack a second escape in front.
  task automatic encode_byte(input logic [7:0] b);
    if (b == sb.sync_byte || b == sb.esc_byte || $urandom_range(99) < 8) begin
      if ($urandom_range(99) < 10) send_byte(sb.esc_byte);
      send_byte(sb.esc_byte);
      send_byte(b - 8'd1);
    end else begin
      send_byte(b);
    end
  endtask

  // One frame with random content; some are cut short (the next sync then
  // restarts decoding) and some carry a bad checksum.
  task automatic send_frame();
    logic [7:0] addr;
    logic [7:0] len;
    logic [7:0] sum;
    logic [7:0] b;
    int         pick;
    int         cut;
    pick = $urandom_range(99);
    if (pick < 2)       len = 8'($urandom_range(255, 64));
    else if (pick < 8)  len = 8'd0;
    else if (pick < 14) len = 8'd1;
    else                len = 8'($urandom_range(9, 2));
    cut = ($urandom_range(99) < 10) ? $urandom_range(int'(len) + 1, 0) : -1;
    send_byte(sb.sync_byte);
    addr = 8'($urandom_range(255));
    encode_byte(addr);
    sum = addr;
    if (cut == 0) return;
    encode_byte(len);
    sum = sum + len;
    if (len == 8'd0) return;
    for (int i = 1; i < int'(len); i++) begin
      if (i == cut) return;
      b = 8'($urandom_range(255));
      encode_byte(b);
      sum = sum + b;
    end
    if ($urandom_range(99) < 20) sum = sum + 8'($urandom_range(255, 1));
    encode_byte(sum);
  endtask

  // A few stray bytes, codes included.
  task automatic send_noise();
    int n;
    int pick;
    n = $urandom_range(4, 1);
    repeat (n) begin
      pick = $urandom_range(9);
      if (pick == 0)      send_byte(sb.sync_byte);
      else if (pick == 1) send_byte(sb.esc_byte);
      else                send_byte(8'($urandom_range(255)));
    end
  endtask

  // Drop valid, wait for every owed result, then let the pipeline drain.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write both code registers on consecutive edges.
  task automatic program_codes(input logic [7:0] sync_val, input logic [7:0] esc_val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_SYNC;
    cfg_data_i <= sync_val;
    @(posedge clk_i);
    sb.set_reg(CFG_SYNC, sync_val);
    cfg_idx_i  <= CFG_ESC;
    cfg_data_i <= esc_val;
    @(posedge clk_i);
    sb.set_reg(CFG_ESC, esc_val);
    cfg_we_i <= 1'b0;
  endtask

  // Directed frames under the reset codes: stray bytes before any sync, a
  // length-one frame, an escaped FF wrapping to a zero length, a double
  // escape, a sync that restarts a frame over a pending escape, an escaped
  // payload byte and a bad checksum.
  task automatic send_directed();
    logic [7:0] seq[$];
    seq = '{8'h12, 8'hD0,
            8'hE0, 8'h00, 8'h01, 8'h01, 8'h33,
            8'hE0, 8'hFF, 8'hD0, 8'hFF,
            8'hE0, 8'hD0, 8'hD0, 8'hDF, 8'h03, 8'h80, 8'hD0, 8'hE0,
            8'h7F, 8'h02, 8'hD0, 8'hCF, 8'h00};
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  initial begin
    logic [7:0] sync_tab[NUM_PHASES];
    logic [7:0] esc_tab[NUM_PHASES];
    int         target;
    sb = new();
    // Reset codes, both extremes, sync equal to escape, then random codes.
    sync_tab = '{8'hE0, 8'h00, 8'hFF, 8'h5A, 8'h00, 8'h00};
    esc_tab  = '{8'hD0, 8'hFF, 8'h00, 8'h5A, 8'h00, 8'h00};
    for (int p = 4; p < NUM_PHASES; p++) begin
      sync_tab[p] = 8'($urandom_range(255));
      esc_tab[p]  = 8'($urandom_range(255));
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int p = 0; p < NUM_PHASES; p++) begin
      // Receiver sparse first, then sender sparse, then both at full rate.
      if (p < 2) begin
        send_idle_pct = 26;
        recv_idle_pct = 87;
      end else if (p < 4) begin
        send_idle_pct = 87;
        recv_idle_pct = 26;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p > 0) settle();
      program_codes(sync_tab[p], esc_tab[p]);
      if (p == 0) send_directed();
      target = bytes_sent + PHASE_QUOTA;
      while (bytes_sent < target) begin
        if ($urandom_range(99) < 12) send_noise();
        else send_frame();
      end
    end
    settle();

    $display("covered %0d raw bytes under %0d code settings, %0d results checked",
             bytes_sent, NUM_PHASES, sb.checked);
    $display("%0d frames closed, %0d with a matching checksum",
             sb.frames_closed, sb.good_sums);
    if (sb.failures == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/sfr_pkg.sv
rtl/sfr_decode.sv
rtl/serial_frame_receiver.sv
sim/tb.sv
